### design/pls_pkg.sv
`default_nettype none

package pls_pkg;

   // list bound and fixed field widths
   localparam int PLS_CAPACITY = 32;
   localparam int PLS_VALUE_W  = 32;
   localparam int PLS_POS_W    = 7;
   localparam int PLS_COUNT_W  = 7;
   localparam int PLS_OP_W     = 3;
   localparam int PLS_STATUS_W = 2;

   // request operation codes
   typedef enum logic [PLS_OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_DISPLAY   = 3'd6,
      OP_UNUSED    = 3'd7
   } op_type;

   // response status codes
   typedef enum logic [PLS_STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DISP_RD,
      S_DISP_OUT,
      S_RESPOND
   } state_type;

endpackage

`default_nettype wire

### design/pls_ram.sv
`default_nettype none

module pls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read held while not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/positional_list_store.sv
// Bounded ordered list of signed 32-bit values addressed by 1-based positions.
// Request channel (req_*): tuser carries the operation, tdata the value and
// the position. Response channel (rsp_*): tdata carries status, element and
// count, tuser marks a displayed element, tlast marks the final response of
// a request. Insert and delete give one response; display gives one response
// per element (one empty response for an empty list).
// The block takes one request at a time; req_tready is low until the last
// response of the current request has been loaded into the output register.
// Elements live in a single-port-read, single-port-write RAM; moving them
// goes through one index adder, each element read and then written back.
// An error or an empty display goes straight to the response; a display
// reads each element from the RAM before loading it into the output register.
// The next request is taken in the cycle after the last load.
// Reset empties the list at once (no clearing pass).
// When the receiver stalls, the response stays in the output register and
// the sequencer waits before loading the next one.
`default_nettype none

module positional_list_store
   import pls_pkg::*;
#(
   parameter int CAPACITY = PLS_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // value[31:0], position[38:32], zero pad
   input  wire logic [2:0]  req_tuser,  // operation[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // status[1:0], element[33:2], count[40:34]
   output logic             rsp_tuser,  // element_valid
   output logic             rsp_tlast   // last
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   // request fields
   op_type                        req_op;
   logic signed [PLS_VALUE_W-1:0] req_value;
   logic [PLS_POS_W-1:0]          req_position;

   assign req_op       = op_type'(req_tuser);
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[38:32];

   // sequencer and list state
   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              idx_ff, idx_in;
   logic [CNT_W-1:0]              target_ff, target_in;
   logic                          insert_ff, insert_in;
   logic signed [PLS_VALUE_W-1:0] value_ff, value_in;
   status_type                    status_ff, status_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   status_type                    rsp_status_ff, rsp_status_in;
   logic signed [PLS_VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic                          rsp_evalid_ff, rsp_evalid_in;
   logic [CNT_W-1:0]              rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   // ram port
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [PLS_VALUE_W-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [ADDR_W-1:0]      ram_rd_addr;
   logic [PLS_VALUE_W-1:0] ram_rd_data;

   // shared index unit and compares
   logic [CNT_W-1:0] step;
   logic             more_shift;
   logic             out_free;
   logic             load_rsp;
   logic             req_accept;
   logic [7:0]       pos_ext;
   logic [7:0]       cnt_ext;
   logic             ins_pos_ok;
   logic             del_pos_ok;
   logic             is_full;
   logic             is_empty;
   logic [CNT_W-1:0] pos_index;

   assign step       = insert_ff ? (idx_ff - CNT_W'(1)) : (idx_ff + CNT_W'(1));
   assign more_shift = insert_ff ? (idx_ff > target_ff) : (step < count_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   assign pos_ext    = {1'b0, req_position};
   assign cnt_ext    = 8'(count_ff);
   assign ins_pos_ok = (req_position != '0) && (pos_ext <= cnt_ext + 8'd1);
   assign del_pos_ok = (req_position != '0) && (pos_ext <= cnt_ext);
   assign is_full    = (cnt_ext >= 8'(CAPACITY));
   assign is_empty   = (count_ff == '0);
   assign pos_index  = CNT_W'(req_position - PLS_POS_W'(1));

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response payload
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      target_ff      <= target_in;
      insert_ff      <= insert_in;
      value_ff       <= value_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_evalid_ff  <= rsp_evalid_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // sequencer next state and outputs
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      target_in      = target_ff;
      insert_in      = insert_ff;
      value_in       = value_ff;
      status_in      = status_ff;
      load_rsp       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_evalid_in  = rsp_evalid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff[ADDR_W-1:0];
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = step[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in  = req_value;
               status_in = ST_OK;
               state_in  = S_RESPOND;
               case (req_op)
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                     insert_in = 1'b1;
                     idx_in    = count_ff;
                     if (req_op == OP_INS_FRONT) begin
                        target_in = '0;
                     end else if (req_op == OP_INS_BACK) begin
                        target_in = count_ff;
                     end else begin
                        target_in = pos_index;
                     end
                     if (req_op == OP_INS_POS && !ins_pos_ok) begin
                        status_in = ST_INVALID;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                     insert_in = 1'b0;
                     if (req_op == OP_DEL_FRONT) begin
                        idx_in = '0;
                     end else if (req_op == OP_DEL_BACK) begin
                        idx_in = count_ff - CNT_W'(1);
                     end else begin
                        idx_in = pos_index;
                     end
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (req_op == OP_DEL_POS && !del_pos_ok) begin
                        status_in = ST_INVALID;
                     end else begin
                        state_in = S_SHIFT_RD;
                     end
                  end
                  OP_DISPLAY: begin
                     idx_in = '0;
                     if (!is_empty) begin
                        state_in = S_DISP_RD;
                     end
                  end
                  default: begin
                     status_in = ST_INVALID;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            if (more_shift) begin
               ram_rd_en = 1'b1;
               state_in  = S_SHIFT_WR;
            end else if (insert_ff) begin
               // drop the new value into the opened slot
               ram_wr_en   = 1'b1;
               ram_wr_addr = target_ff[ADDR_W-1:0];
               ram_wr_data = value_ff;
               count_in    = count_ff + CNT_W'(1);
               state_in    = S_RESPOND;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_RESPOND;
            end
         end
         S_SHIFT_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = step;
            state_in  = S_SHIFT_RD;
         end
         S_DISP_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff[ADDR_W-1:0];
            state_in    = S_DISP_OUT;
         end
         S_DISP_OUT: begin
            if (out_free) begin
               load_rsp       = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_element_in = ram_rd_data;
               rsp_evalid_in  = 1'b1;
               rsp_count_in   = count_ff;
               rsp_last_in    = ((idx_ff + CNT_W'(1)) == count_ff);
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_DISP_RD;
               end
            end
         end
         S_RESPOND: begin
            if (out_free) begin
               load_rsp       = 1'b1;
               rsp_status_in  = status_ff;
               rsp_element_in = '0;
               rsp_evalid_in  = 1'b0;
               rsp_count_in   = count_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // output register valid
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // element storage
   pls_ram #(
      .WIDTH(PLS_VALUE_W),
      .DEPTH(CAPACITY)
   ) u_pls_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, PLS_COUNT_W'(rsp_count_ff), rsp_element_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_evalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   // list never grows past its bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(count_ff) <= (CNT_W + 1)'(CAPACITY))
      else $error("element count above capacity");

   // count moves by at most one per request
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("element count jumped");

   // an accepted request always starts the sequencer
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("request accepted without leaving idle");

   // displayed elements only come from a non-empty list
   a_disp_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evalid_ff) |-> (rsp_count_ff != '0))
      else $error("displayed element from empty list");

   // the ram is never written while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_wr_en)
      else $error("ram write while idle");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
   import pls_pkg::*;

   localparam int LIST_DEPTH    = PLS_CAPACITY;
   // longest quiet stretch: long response hold plus a full-depth shift plus idling
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 100;
   localparam int LOG_LIMIT     = 100;

   // one response as the list should produce it
   typedef struct packed {
      status_type  status;
      logic [31:0] element;
      logic        elem_valid;
      logic [6:0]  count;
      logic        last;
   } list_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // value[31:0], position[38:32], zero pad
   logic [2:0]  req_tuser;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // status[1:0], element[33:2], count[40:34]
   logic        rsp_tuser;   // element_valid
   logic        rsp_tlast;   // last

   // shadow copy of the list and responses still owed
   logic [31:0]  list_contents[$];
   list_rsp_type expected_rsp[$];

   int mismatches   = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_cycles  = 0;

   positional_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic list_rsp_type make_rsp(input status_type st, input logic [31:0] elem,
                                             input logic ev, input int n, input logic lst);
      list_rsp_type r;
      r.status     = st;
      r.element    = elem;
      r.elem_valid = ev;
      r.count      = 7'(n);
      r.last       = lst;
      return r;
   endfunction

   // apply one accepted request to the shadow list and queue its responses
   function automatic void apply_list_op(input op_type op, input logic [31:0] val,
                                         input logic [6:0] pos);
      int         n;
      int         p;
      status_type st;
      n  = list_contents.size();
      p  = int'(pos);
      st = ST_OK;
      case (op)
         OP_INS_FRONT: begin
            if (n >= LIST_DEPTH) st = ST_FULL;
            else list_contents.push_front(val);
         end
         OP_INS_BACK: begin
            if (n >= LIST_DEPTH) st = ST_FULL;
            else list_contents.push_back(val);
         end
         OP_INS_POS: begin
            // a bad position wins over a full list
            if (p < 1 || p > n + 1) st = ST_INVALID;
            else if (n >= LIST_DEPTH) st = ST_FULL;
            else list_contents.insert(p - 1, val);
         end
         OP_DEL_FRONT: begin
            if (n == 0) st = ST_EMPTY;
            else void'(list_contents.pop_front());
         end
         OP_DEL_BACK: begin
            if (n == 0) st = ST_EMPTY;
            else void'(list_contents.pop_back());
         end
         OP_DEL_POS: begin
            // an empty list wins over a bad position
            if (n == 0) st = ST_EMPTY;
            else if (p < 1 || p > n) st = ST_INVALID;
            else list_contents.delete(p - 1);
         end
         OP_DISPLAY: begin
            if (n == 0) begin
               expected_rsp.push_back(make_rsp(ST_OK, 32'd0, 1'b0, 0, 1'b1));
            end else begin
               for (int i = 0; i < n; i++)
                  expected_rsp.push_back(make_rsp(ST_OK, list_contents[i], 1'b1, n,
                                                  i == n - 1));
            end
            return;
         end
         default: st = ST_INVALID;
      endcase
      expected_rsp.push_back(make_rsp(st, 32'd0, 1'b0, list_contents.size(), 1'b1));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      // keep the log short on a badly broken build
      if (mismatches <= LOG_LIMIT)
         $display("%0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   // send one request, with an optional idle burst ahead of it
   task automatic send_request(input op_type op, input logic [31:0] val,
                               input logic [6:0] pos);
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, pos, val};
      do @(posedge clock); while (!req_tready);
      apply_list_op(op, val, pos);
   endtask

   // random request; grow_pct steers the mix toward inserts or deletes
   task automatic send_random(input int grow_pct);
      op_type      op;
      logic [31:0] val;
      logic [6:0]  pos;
      int          n;
      int          r;
      n = list_contents.size();
      r = $urandom_range(0, 99);
      if (r < 10) op = OP_DISPLAY;
      else if (r < 12) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < grow_pct) op = op_type'(3'($urandom_range(0, 2)));
      else op = op_type'(3'($urandom_range(3, 5)));
      val = $urandom;
      case ($urandom_range(0, 9))
         0: val = 32'h8000_0000;
         1: val = 32'h7fff_ffff;
         default: ;
      endcase
      // mostly legal positions, sometimes anything the field holds
      if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
      else if (op == OP_INS_POS) pos = 7'($urandom_range(1, n + 1));
      else if (n == 0) pos = 7'd1;
      else pos = 7'($urandom_range(1, n));
      send_request(op, val, pos);
   endtask

   // sender pauses until every response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   // display, every delete, bad-position inserts and the unused code on an empty list
   task automatic test_empty_list();
      send_request(OP_DISPLAY,   32'd0, 7'd0);
      send_request(OP_DEL_FRONT, 32'd0, 7'd0);
      send_request(OP_DEL_BACK,  32'd0, 7'd0);
      send_request(OP_DEL_POS,   32'd0, 7'd3);
      send_request(OP_DEL_POS,   32'd0, 7'd0);
      send_request(OP_INS_POS,   32'd7, 7'd0);
      send_request(OP_INS_POS,   32'd7, 7'd2);
      send_request(OP_UNUSED,    32'd0, 7'd0);
   endtask

   // extreme values, boundary positions and the unused code
   task automatic test_edge_values();
      send_request(OP_INS_POS,   32'h0000_0000, 7'd1);
      send_request(OP_INS_FRONT, 32'h8000_0000, 7'd0);
      send_request(OP_INS_BACK,  32'h7fff_ffff, 7'd0);
      send_request(OP_INS_POS,   32'hffff_ffff, 7'd4);
      send_request(OP_INS_POS,   32'h5555_5555, 7'd2);
      send_request(OP_DISPLAY,   32'd0, 7'd0);
      send_request(OP_DEL_POS,   32'd0, 7'd0);
      send_request(OP_DEL_POS,   32'd0, 7'd6);
      send_request(OP_DEL_POS,   32'd0, 7'd127);
      send_request(OP_INS_POS,   32'haaaa_aaaa, 7'd127);
      send_request(OP_UNUSED,    32'hffff_ffff, 7'd127);
      send_request(OP_DEL_POS,   32'd0, 7'd3);
      send_request(OP_DEL_FRONT, 32'd0, 7'd0);
      send_request(OP_DEL_BACK,  32'd0, 7'd0);
      send_request(OP_DISPLAY,   32'd0, 7'd0);
   endtask

   // fill to capacity, hit the full status, show all, then empty again
   task automatic test_full_list();
      op_type op;
      int     n;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      while (list_contents.size() < LIST_DEPTH) begin
         n  = list_contents.size();
         op = op_type'(3'($urandom_range(0, 2)));
         send_request(op, $urandom, 7'($urandom_range(1, n + 1)));
      end
      send_request(OP_INS_FRONT, 32'h1234_5678, 7'd0);
      send_request(OP_INS_BACK,  32'h1234_5678, 7'd0);
      send_request(OP_INS_POS,   32'h1234_5678, 7'(LIST_DEPTH + 1));
      send_request(OP_INS_POS,   32'h1234_5678, 7'd1);
      send_request(OP_INS_POS,   32'h1234_5678, 7'(LIST_DEPTH + 2));
      send_request(OP_DISPLAY,   32'd0, 7'd0);
      while (list_contents.size() > 0) begin
         n  = list_contents.size();
         op = op_type'(3'($urandom_range(3, 5)));
         send_request(op, 32'd0, 7'($urandom_range(1, n)));
      end
      wait_drained();
   endtask

   // receiver holds off while requests keep coming, so the block stalls
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int i = 0; i < 6; i++)
         send_request(OP_INS_BACK, $urandom, 7'd0);
      hold_cycles = 200;
      for (int i = 0; i < 12; i++)
         send_random(50);
      wait_drained();
   endtask

   // long random walk between empty and full
   task automatic test_random_mix();
      for (int i = 0; i < 300; i++) begin
         // stretches with idling on both sides and stretches without
         if ((i / 60) % 3 == 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 30;
            rsp_idle_pct = 30;
         end
         send_random(((i / 40) % 2 == 0) ? 75 : 25);
      end
   endtask

   // closing stretch at full rate
   task automatic test_quiet_tail();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int i = 0; i < 60; i++)
         send_random((i < 30) ? 70 : 30);
   endtask

   // response ready with random idle bursts and the long hold
   initial begin : rsp_ready_driver
      int idle_left;
      idle_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_tready <= 1'b0;
            idle_left = $urandom_range(0, 9);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare every accepted response with the oldest one owed
   initial begin : rsp_checker
      list_rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_mismatch("status", rsp_tdata[1:0], want.status);
               if (rsp_tdata[33:2] !== want.element)
                  report_mismatch("element", rsp_tdata[33:2], want.element);
               if (rsp_tuser !== want.elem_valid)
                  report_mismatch("element_valid", rsp_tuser, want.elem_valid);
               if (rsp_tdata[40:34] !== want.count)
                  report_mismatch("count", rsp_tdata[40:34], want.count);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", rsp_tlast, want.last);
            end
         end
      end
   end

   // end the run if nothing moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // reset, then the tests in turn
   initial begin : main_sequence
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_INS_FRONT;
      req_tdata  <= 40'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_edge_values();
      wait_drained();
      test_full_list();
      test_backpressure();
      test_random_mix();
      wait_drained();
      test_quiet_tail();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
